FILE: hdl/fcj_pkg.sv
package fcj_pkg;

    localparam int FLD_W     = 24;
    localparam int IN_W      = 3 * FLD_W;
    localparam int OUT_W     = 11 * FLD_W;
    localparam int STAT_W    = 2;
    localparam int TOL_W     = 23;
    localparam logic [TOL_W-1:0] TOL_RESET = 23'd4194283;
    localparam int PROD_W    = 2 * FLD_W;

    localparam int RAD_W     = PROD_W;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SQ_PER    = 4;
    localparam int SQ_STG    = ROOT_W / SQ_PER;
    localparam int SQ_REM_W  = ROOT_W + 2;

    localparam int Q_W       = FLD_W;
    localparam int MAG_W     = 62;
    localparam int DEN_W     = PROD_W;
    localparam int DD_W      = DEN_W + 1;
    localparam int REM_W     = DD_W + Q_W;
    localparam int DV_PER    = 2;
    localparam int DV_STG    = Q_W / DV_PER;

    localparam int Q_FRAC    = 16;
    localparam int DIR_SH    = 38;
    localparam int SC_SH     = 6;
    localparam int RS_W      = ROOT_W - SC_SH + 1;

    localparam logic [Q_W-1:0] Q_POS_MAX = 24'h7fffff;
    localparam logic [Q_W-1:0] Q_NEG_MAX = 24'h800000;

    localparam int ST_IN     = 0;
    localparam int ST_MUL    = 1;
    localparam int ST_SUM    = 2;
    localparam int ST_SQ0    = 3;
    localparam int ST_SEL    = ST_SQ0 + SQ_STG;
    localparam int ST_DV0    = ST_SEL + 1;
    localparam int ST_OUT    = ST_DV0 + DV_STG + 1;
    localparam int NSTG      = ST_OUT + 1;

    localparam int NDIV      = 8;
    localparam int DV_A      = 0;
    localparam int DV_B      = 1;
    localparam int DV_C      = 2;
    localparam int DV_D      = 3;
    localparam int DV_E      = 4;
    localparam int DV_F      = 5;
    localparam int DV_G      = 6;
    localparam int DV_H      = 7;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           ovf;
        logic           dz;
        logic           mz;
    } div_res_t;

endpackage

FILE: hdl/fcj_sqrt.sv
module fcj_sqrt (
    input  logic                        aclk,
    input  logic [fcj_pkg::SQ_STG-1:0]  en,
    input  logic [fcj_pkg::RAD_W-1:0]   rad,
    output logic [fcj_pkg::ROOT_W-1:0]  root
);
    import fcj_pkg::*;

    logic [RAD_W-1:0]    rad_reg  [SQ_STG];
    logic [SQ_REM_W-1:0] rem_reg  [SQ_STG];
    logic [ROOT_W-1:0]   root_reg [SQ_STG];

    genvar g;
    generate
        for (g = 0; g < SQ_STG; g++) begin : g_stg
            logic [RAD_W-1:0]    rad_in;
            logic [RAD_W-1:0]    rad_next;
            logic [SQ_REM_W-1:0] rem_in;
            logic [SQ_REM_W-1:0] rem_next;
            logic [SQ_REM_W-1:0] trial;
            logic [ROOT_W-1:0]   root_in;
            logic [ROOT_W-1:0]   root_next;

            if (g == 0) begin : g_first
                assign rad_in  = rad;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_rest
                assign rad_in  = rad_reg[g-1];
                assign rem_in  = rem_reg[g-1];
                assign root_in = root_reg[g-1];
            end

            always_comb begin
                rad_next  = rad_in;
                rem_next  = rem_in;
                root_next = root_in;
                trial     = '0;
                for (int j = 0; j < SQ_PER; j++) begin
                    rem_next = {rem_next[SQ_REM_W-3:0], rad_next[RAD_W-1 -: 2]};
                    rad_next = {rad_next[RAD_W-3:0], 2'b00};
                    trial    = {root_next, 2'b01};
                    if (rem_next >= trial) begin
                        rem_next  = rem_next - trial;
                        root_next = {root_next[ROOT_W-2:0], 1'b1};
                    end else begin
                        root_next = {root_next[ROOT_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (en[g]) begin
                    rad_reg[g]  <= rad_next;
                    rem_reg[g]  <= rem_next;
                    root_reg[g] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[SQ_STG-1];

endmodule

FILE: hdl/fcj_div.sv
module fcj_div (
    input  logic                        aclk,
    input  logic [fcj_pkg::DV_STG:0]    en,
    input  logic [fcj_pkg::MAG_W-1:0]   mag,
    input  logic [fcj_pkg::DEN_W-1:0]   den,
    output fcj_pkg::div_res_t           res
);
    import fcj_pkg::*;

    logic [REM_W-1:0] rem_reg [DV_STG+1];
    logic [DD_W-1:0]  dd_reg  [DV_STG+1];
    div_res_t         res_reg [DV_STG+1];

    logic [REM_W-1:0] num0;
    logic [DD_W-1:0]  dd0;
    div_res_t         res0;

    always_comb begin
        num0     = REM_W'({mag, 1'b0}) + REM_W'(den);
        dd0      = {den, 1'b0};
        res0.q   = '0;
        res0.ovf = num0 >= (REM_W'(dd0) << Q_W);
        res0.dz  = den == '0;
        res0.mz  = mag == '0;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0] <= num0;
            dd_reg[0]  <= dd0;
            res_reg[0] <= res0;
        end
    end

    genvar g;
    generate
        for (g = 1; g <= DV_STG; g++) begin : g_stg
            logic [REM_W-1:0] rem_next;
            logic [REM_W-1:0] sub;
            div_res_t         res_next;

            always_comb begin
                rem_next = rem_reg[g-1];
                res_next = res_reg[g-1];
                sub      = '0;
                for (int j = 0; j < DV_PER; j++) begin
                    sub = REM_W'(dd_reg[g-1]) << (Q_W - 1 - ((g - 1) * DV_PER + j));
                    if (rem_next >= sub) begin
                        rem_next   = rem_next - sub;
                        res_next.q = {res_next.q[Q_W-2:0], 1'b1};
                    end else begin
                        res_next.q = {res_next.q[Q_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (en[g]) begin
                    rem_reg[g] <= rem_next;
                    dd_reg[g]  <= dd_reg[g-1];
                    res_reg[g] <= res_next;
                end
            end
        end
    endgenerate

    assign res = res_reg[DV_STG];

endmodule

FILE: hdl/free_to_curvilinear_jacobian.sv
// 24 register stages, each with its own valid bit; throughput is one direction per cycle
// while m_tready does not stall the result side. The stage count is set by the two 6-stage
// square roots and the 13-stage dividers.
// A stall on the result side fills empty stages before it holds s_tready low.
// Reset (aresetn low at a clock edge) drops all items in flight and restores the tolerance.
module free_to_curvilinear_jacobian (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [fcj_pkg::IN_W-1:0]    s_tdata,   // dir_x, dir_y, dir_z
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // j_0_0, j_0_1, j_0_2, j_1_0, j_1_1, j_1_2, j_2_4, j_2_5, j_3_4, j_3_5, j_3_6
    output logic [fcj_pkg::OUT_W-1:0]   m_tdata,
    output logic [fcj_pkg::STAT_W-1:0]  m_tuser,   // frame_status
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fcj_pkg::TOL_W-1:0]   cfg_data
);
    import fcj_pkg::*;

    typedef struct packed {
        logic [FLD_W-1:0]  ax;
        logic [FLD_W-1:0]  ay;
        logic [FLD_W-1:0]  az;
        logic [PROD_W-1:0] pxy;
        logic [PROD_W-1:0] pxz;
        logic [PROD_W-1:0] pyz;
        logic              alt;
        logic              sx;
        logic              sy;
        logic              sz;
    } side_t;

    typedef struct packed {
        logic            alt;
        logic            sx;
        logic            sy;
        logic            sz;
        logic [RS_W-1:0] rs;
        logic [RS_W-1:0] rc;
    } tail_t;

    typedef struct packed {
        logic [Q_W-1:0] val;
        logic           flag;
    } sat_t;

    function automatic sat_t sat_q(div_res_t r, logic neg);
        sat_t           o;
        logic [Q_W-1:0] lim;
        lim    = neg ? Q_NEG_MAX : Q_POS_MAX;
        o.flag = r.dz | r.ovf | (r.q > lim);
        if (r.dz && r.mz) begin
            o.val = '0;
        end else if (o.flag) begin
            o.val = lim;
        end else begin
            o.val = neg ? -r.q : r.q;
        end
        return o;
    endfunction

    logic [TOL_W-1:0]  tol_reg;
    logic [NSTG-1:0]   vld_reg;
    logic [NSTG:0]     rdy;
    logic [NSTG-1:0]   en;

    logic [FLD_W-1:0]  x_reg, y_reg, z_reg;
    logic [FLD_W-1:0]  ax, ay, az;
    logic [PROD_W-1:0] xx_reg, yy_reg, zz_reg;
    logic [RAD_W-1:0]  sum_s_reg, sum_c_reg;
    side_t             side_reg [ST_MUL:ST_SEL];
    logic [ROOT_W-1:0] root_s, root_c;
    logic [ROOT_W-1:0] s_reg, d_reg;
    logic [PROD_W-1:0] ssq_reg;
    logic [ROOT_W:0]   rs_sum, rc_sum;
    tail_t             tail_reg [ST_SEL:ST_OUT-1];

    logic [MAG_W-1:0]  dv_mag [NDIV];
    logic [DEN_W-1:0]  dv_den [NDIV];
    div_res_t          dv_res [NDIV];

    tail_t             tl;
    sat_t              sa0, sa2, sb, sc, sd, se, sf, sg, sh;
    logic [FLD_W-1:0]  rs_ext, rc_ext;
    logic [OUT_W-1:0]  m_data_next, m_data_reg;
    logic [STAT_W-1:0] m_user_next, m_user_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    // pipeline control: a stage loads when empty or when the next one loads
    always_comb begin
        rdy[NSTG] = m_tready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign en       = rdy[NSTG-1:0];
    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= (en & {vld_reg[NSTG-2:0], s_tvalid}) | (~en & vld_reg);
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (en[ST_IN]) begin
            x_reg <= s_tdata[0*FLD_W +: FLD_W];
            y_reg <= s_tdata[1*FLD_W +: FLD_W];
            z_reg <= s_tdata[2*FLD_W +: FLD_W];
        end
    end

    // magnitudes and products
    assign ax = x_reg[FLD_W-1] ? -x_reg : x_reg;
    assign ay = y_reg[FLD_W-1] ? -y_reg : y_reg;
    assign az = z_reg[FLD_W-1] ? -z_reg : z_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_MUL]) begin
            xx_reg               <= ax * ax;
            yy_reg               <= ay * ay;
            zz_reg               <= az * az;
            side_reg[ST_MUL].ax  <= ax;
            side_reg[ST_MUL].ay  <= ay;
            side_reg[ST_MUL].az  <= az;
            side_reg[ST_MUL].pxy <= ax * ay;
            side_reg[ST_MUL].pxz <= ax * az;
            side_reg[ST_MUL].pyz <= ay * az;
            side_reg[ST_MUL].alt <= az >= FLD_W'(tol_reg);
            side_reg[ST_MUL].sx  <= x_reg[FLD_W-1];
            side_reg[ST_MUL].sy  <= y_reg[FLD_W-1];
            side_reg[ST_MUL].sz  <= z_reg[FLD_W-1];
        end
        for (int i = ST_SUM; i <= ST_SEL; i++) begin
            if (en[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            sum_s_reg <= xx_reg + yy_reg;
            sum_c_reg <= yy_reg + zz_reg;
        end
    end

    fcj_sqrt u_sqrt_s (
        .aclk (aclk),
        .en   (en[ST_SQ0 +: SQ_STG]),
        .rad  (sum_s_reg),
        .root (root_s)
    );

    fcj_sqrt u_sqrt_c (
        .aclk (aclk),
        .en   (en[ST_SQ0 +: SQ_STG]),
        .rad  (sum_c_reg),
        .root (root_c)
    );

    // frame select, divisor square, scaled roots
    assign rs_sum = {1'b0, root_s} + (ROOT_W + 1)'(32);
    assign rc_sum = {1'b0, root_c} + (ROOT_W + 1)'(32);

    always_ff @(posedge aclk) begin
        if (en[ST_SEL]) begin
            s_reg                <= root_s;
            d_reg                <= side_reg[ST_SEL-1].alt ? root_c : root_s;
            ssq_reg              <= root_s * root_s;
            tail_reg[ST_SEL].alt <= side_reg[ST_SEL-1].alt;
            tail_reg[ST_SEL].sx  <= side_reg[ST_SEL-1].sx;
            tail_reg[ST_SEL].sy  <= side_reg[ST_SEL-1].sy;
            tail_reg[ST_SEL].sz  <= side_reg[ST_SEL-1].sz;
            tail_reg[ST_SEL].rs  <= rs_sum[ROOT_W:SC_SH];
            tail_reg[ST_SEL].rc  <= rc_sum[ROOT_W:SC_SH];
        end
        for (int i = ST_DV0; i <= ST_OUT - 1; i++) begin
            if (en[i]) begin
                tail_reg[i] <= tail_reg[i-1];
            end
        end
    end

    always_comb begin
        dv_mag[DV_A] = MAG_W'(side_reg[ST_SEL].ay) << Q_FRAC;
        dv_den[DV_A] = DEN_W'(d_reg);
        dv_mag[DV_B] = MAG_W'(side_reg[ST_SEL].alt ? side_reg[ST_SEL].az
                                                   : side_reg[ST_SEL].ax) << Q_FRAC;
        dv_den[DV_B] = DEN_W'(d_reg);
        dv_mag[DV_C] = MAG_W'(side_reg[ST_SEL].pxz);
        dv_den[DV_C] = DEN_W'(d_reg) << SC_SH;
        dv_mag[DV_D] = MAG_W'(side_reg[ST_SEL].alt ? side_reg[ST_SEL].pxy
                                                   : side_reg[ST_SEL].pyz);
        dv_den[DV_D] = DEN_W'(d_reg) << SC_SH;
        dv_mag[DV_E] = MAG_W'(side_reg[ST_SEL].pxz);
        dv_den[DV_E] = DEN_W'(s_reg) << SC_SH;
        dv_mag[DV_F] = MAG_W'(side_reg[ST_SEL].pyz);
        dv_den[DV_F] = DEN_W'(s_reg) << SC_SH;
        dv_mag[DV_G] = MAG_W'(side_reg[ST_SEL].ay) << DIR_SH;
        dv_den[DV_G] = ssq_reg;
        dv_mag[DV_H] = MAG_W'(side_reg[ST_SEL].ax) << DIR_SH;
        dv_den[DV_H] = ssq_reg;
    end

    genvar u;
    generate
        for (u = 0; u < NDIV; u++) begin : g_div
            fcj_div u_div (
                .aclk (aclk),
                .en   (en[ST_DV0 +: DV_STG + 1]),
                .mag  (dv_mag[u]),
                .den  (dv_den[u]),
                .res  (dv_res[u])
            );
        end
    endgenerate

    // sign, saturate, pack
    always_comb begin
        tl     = tail_reg[ST_OUT-1];
        rs_ext = FLD_W'(tl.rs);
        rc_ext = FLD_W'(tl.rc);
        sa0    = sat_q(dv_res[DV_A], !tl.sy);
        sa2    = sat_q(dv_res[DV_A], tl.sy);
        sb     = sat_q(dv_res[DV_B], tl.alt ? !tl.sz : tl.sx);
        sc     = sat_q(dv_res[DV_C], !(tl.sx ^ tl.sz));
        sd     = sat_q(dv_res[DV_D], tl.alt ? !(tl.sx ^ tl.sy) : !(tl.sy ^ tl.sz));
        se     = sat_q(dv_res[DV_E], tl.sx ^ tl.sz);
        sf     = sat_q(dv_res[DV_F], tl.sy ^ tl.sz);
        sg     = sat_q(dv_res[DV_G], !tl.sy);
        sh     = sat_q(dv_res[DV_H], tl.sx);

        m_data_next = {
            -rs_ext,
            sf.val,
            se.val,
            sh.val,
            sg.val,
            tl.alt ? sc.val : rs_ext,
            sd.val,
            tl.alt ? rc_ext : sc.val,
            tl.alt ? sa2.val : {FLD_W{1'b0}},
            sb.val,
            tl.alt ? {FLD_W{1'b0}} : sa0.val
        };
        m_user_next = {
            (tl.alt ? sa2.flag : sa0.flag) | sb.flag | sc.flag | sd.flag
                | se.flag | sf.flag | sg.flag | sh.flag,
            tl.alt
        };
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tdata = m_data_reg;
    assign m_tuser = m_user_reg;

endmodule

FILE: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fcj_pkg::*;

    typedef struct {
        logic [OUT_W-1:0]  entries;
        logic [STAT_W-1:0] status;
    } jac_t;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        bit                 known;
        logic [23:0]        j24;
        logic [23:0]        j36;
        logic [1:0]         st;
    } vec_row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic [STAT_W-1:0] m_tuser;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [TOL_W-1:0] cfg_data = '0;

    free_to_curvilinear_jacobian DUT (.*);

    always #5 aclk = ~aclk;

    logic [TOL_W-1:0] tol_model;
    jac_t jac_expected[$];
    int errors = 0;
    int stall_pct = 33;
    bit hold_off = 0;
    int idle_cycles = 0;
    string field_names[11] = '{"j_0_0", "j_0_1", "j_0_2", "j_1_0", "j_1_1", "j_1_2",
                               "j_2_4", "j_2_5", "j_3_4", "j_3_5", "j_3_6"};

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [23:0] round_quot(longint num, longint unsigned den,
                                               ref bit sat);
        longint unsigned mag, q;
        if (den == 0) begin
            sat = 1;
            if (num > 0) return 24'h7fffff;
            if (num < 0) return 24'h800000;
            return 24'h0;
        end
        mag = (num < 0) ? longint'(-num) : num;
        q = (2 * mag + den) / (2 * den);
        if (num < 0) begin
            if (q > 64'h800000) begin
                sat = 1;
                return 24'h800000;
            end
            return 24'(-longint'(q));
        end
        if (q > 64'h7fffff) begin
            sat = 1;
            return 24'h7fffff;
        end
        return 24'(q);
    endfunction

    function automatic jac_t jacobian(logic signed [23:0] xi, logic signed [23:0] yi,
                                      logic signed [23:0] zi);
        longint x, y, z;
        longint unsigned s, c, az;
        logic [23:0] e[11];
        bit sat, alt;
        jac_t r;
        x = xi;
        y = yi;
        z = zi;
        sat = 0;
        alt = 0;
        s = root64(longint'(x * x) + longint'(y * y));
        az = (z < 0) ? -z : z;
        if (az < tol_model) begin
            e[0] = round_quot(-y * 65536, s, sat);
            e[1] = round_quot(x * 65536, s, sat);
            e[2] = 0;
            e[3] = round_quot(-(x * z), 64 * s, sat);
            e[4] = round_quot(-(y * z), 64 * s, sat);
            e[5] = round_quot(s, 64, sat);
        end else begin
            c = root64(longint'(y * y) + longint'(z * z));
            alt = 1;
            e[0] = 0;
            e[1] = round_quot(-z * 65536, c, sat);
            e[2] = round_quot(y * 65536, c, sat);
            e[3] = round_quot(c, 64, sat);
            e[4] = round_quot(-(x * y), 64 * c, sat);
            e[5] = round_quot(-(x * z), 64 * c, sat);
        end
        e[6] = round_quot(-y * (64'sd1 <<< 38), s * s, sat);
        e[7] = round_quot(x * (64'sd1 <<< 38), s * s, sat);
        e[8] = round_quot(x * z, 64 * s, sat);
        e[9] = round_quot(y * z, 64 * s, sat);
        e[10] = -round_quot(s, 64, sat);
        for (int i = 0; i < 11; i++) r.entries[i*24 +: 24] = e[i];
        r.status = {sat, alt};
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && (s_tvalid && s_tready || m_tvalid && m_tready || cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("[free_to_curvilinear_jacobian] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        jac_t exp_r;
        if (aresetn) begin
            if (hold_off) m_tready <= 0;
            else m_tready <= ($urandom_range(99) >= stall_pct);
            if (m_tvalid && m_tready) begin
                if (jac_expected.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    errors++;
                end else begin
                    exp_r = jac_expected.pop_front();
                    for (int i = 0; i < 11; i++) begin
                        if (m_tdata[i*24 +: 24] !== exp_r.entries[i*24 +: 24]) begin
                            $error("%s expected %h actual %h", field_names[i],
                                   exp_r.entries[i*24 +: 24], m_tdata[i*24 +: 24]);
                            errors++;
                        end
                    end
                    if (m_tuser !== exp_r.status) begin
                        $error("frame_status expected %h actual %h", exp_r.status, m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_tolerance(logic [TOL_W-1:0] v);
        s_tvalid <= 0;
        while (jac_expected.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        tol_model = v;
    endtask

    task automatic send_dir(logic signed [23:0] x, logic signed [23:0] y,
                            logic signed [23:0] z, bit gaps);
        if (gaps && $urandom_range(99) < stall_pct) begin
            s_tvalid <= 0;
            do @(posedge aclk); while ($urandom_range(99) < stall_pct);
        end
        s_tvalid <= 1;
        s_tdata <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
        jac_expected.insert(jac_expected.size(), jacobian(x, y, z));
    endtask

    function automatic logic signed [23:0] unit_comp();
        return 24'($signed($urandom_range(8388608)) - 4194304);
    endfunction

    vec_row_t vectors[14] = '{
        '{24'sd0, 24'sd0, 24'sd0, 1, 24'h0, 24'h0, 2'b10},
        '{24'sd4194304, 24'sd0, 24'sd0, 1, 24'h0, 24'hff0000, 2'b00},
        '{-24'sd4194304, 24'sd0, 24'sd0, 1, 24'h0, 24'hff0000, 2'b00},
        '{24'sd0, 24'sd4194304, 24'sd0, 1, 24'hff0000, 24'hff0000, 2'b00},
        '{24'sd0, 24'sd0, 24'sd4194304, 1, 24'h0, 24'h0, 2'b11},
        '{24'sd0, 24'sd0, -24'sd4194304, 1, 24'h0, 24'h0, 2'b11},
        '{-24'sd8388608, -24'sd8388608, -24'sd8388608, 0, 0, 0, 0},
        '{24'sd8388607, 24'sd8388607, 24'sd8388607, 0, 0, 0, 0},
        '{24'sd2965821, 24'sd2965821, 24'sd0, 0, 0, 0, 0},
        '{24'sd1, 24'sd0, 24'sd1, 0, 0, 0, 0},
        '{24'sd0, 24'sd1, -24'sd1, 0, 0, 0, 0},
        '{24'sd2097152, -24'sd2097152, 24'sd2965821, 0, 0, 0, 0},
        '{-24'sd1000, 24'sd5, 24'sd4194283, 0, 0, 0, 0},
        '{24'sd1000, 24'sd5, 24'sd4194282, 0, 0, 0, 0}
    };

    initial begin
        jac_t r;
        logic signed [23:0] x, y, z;
        tol_model = TOL_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (vectors[i]) begin
            r = jacobian(vectors[i].x, vectors[i].y, vectors[i].z);
            if (vectors[i].known && (r.entries[6*24 +: 24] !== vectors[i].j24 ||
                r.entries[10*24 +: 24] !== vectors[i].j36 || r.status !== vectors[i].st)) begin
                $error("table row %0d expected %h %h %h", i, vectors[i].j24,
                       vectors[i].j36, vectors[i].st);
                errors++;
            end
            send_dir(vectors[i].x, vectors[i].y, vectors[i].z, 1);
        end
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_tolerance(23'd0);
                1: write_tolerance(23'h7fffff);
                2: write_tolerance(23'd4194304);
                3: write_tolerance(23'($urandom_range(4194304)));
                default: write_tolerance(23'd2965821);
            endcase
            if (ph == 2) stall_pct = 0;
            else stall_pct = 33;
            if (ph == 3) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (200) @(posedge aclk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int k = 0; k < 250; k++) begin
                if ($urandom_range(9) == 0) begin
                    x = 24'($urandom);
                    y = 24'($urandom);
                    z = 24'($urandom);
                end else begin
                    x = unit_comp();
                    y = unit_comp();
                    z = unit_comp();
                    if ($urandom_range(7) == 0) begin
                        x = 0;
                        y = 0;
                    end
                    if ($urandom_range(7) == 0) begin
                        y = 0;
                        z = 0;
                    end
                end
                send_dir(x, y, z, ph != 2);
            end
        end
        s_tvalid <= 0;
        while (jac_expected.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (errors == 0)
            $display("[free_to_curvilinear_jacobian] OK");
        else
            $display("[free_to_curvilinear_jacobian] ERROR");
        $finish;
    end
endmodule

FILE: sim.f
hdl/fcj_pkg.sv
hdl/fcj_sqrt.sv
hdl/fcj_div.sv
hdl/free_to_curvilinear_jacobian.sv
bench/testbench.sv
